// ===== rtl/rpd_pkg.sv =====
// row packet deframer package: field widths, limits, sync bytes, codes
// and the command/status structs between controller and datapath
// no dependencies
package rpd_pkg;

  localparam int unsigned MAX_ROW_PIXELS   = 4096;
  localparam int unsigned MAX_FRAME_ROWS   = 4096;
  localparam int unsigned MAX_HEADER_BYTES = 256;
  localparam int unsigned MIN_HEADER_BYTES = 12;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HDR_LEN_W  = 9;
  localparam int unsigned PIX_CNT_W  = 13;
  localparam int unsigned ROWS_W     = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned PIXEL_W    = 16;
  localparam int unsigned ROW_OUT_W  = 13;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned HELD_ROW_W = 16;
  localparam int unsigned POS_W      = 9;

  localparam int unsigned REPLAY_DEPTH = 6;
  localparam int unsigned REPLAY_IDX_W = 3;
  localparam int unsigned REPLAY_FIRST = 4;
  localparam int unsigned ROW_OFS      = 8;
  localparam int unsigned FRAME_OFS    = 10;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h90;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hEB;
  localparam logic [BYTE_W-1:0] SYNC_TAIL   = 8'h00;

  localparam logic [HDR_LEN_W-1:0] HDR_LEN_RESET  = 9'd12;
  localparam logic [PIX_CNT_W-1:0] ROW_PIX_RESET  = 13'd640;
  localparam logic [ROWS_W-1:0]    FRAME_ROW_RESET = 13'd512;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISCARD = 3'd0,
    KIND_HELD    = 3'd1,
    KIND_PIX_LO  = 3'd2,
    KIND_PIX_OUT = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_LENGTH = 2'd0,
    CFG_ROW_PIXELS    = 2'd1,
    CFG_FRAME_ROWS    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                    sel_replay;
    logic [REPLAY_IDX_W-1:0] replay_idx;
    logic                    store_we;
    logic [REPLAY_IDX_W-1:0] store_idx;
    logic                    row_lo_ld;
    logic                    row_hi_ld;
    logic                    frm_lo_ld;
    logic                    frm_hi_ld;
    logic                    low_ld;
    logic                    out_ld;
    kind_e                   out_kind;
    logic [COL_W-1:0]        out_col;
    logic                    out_row_end;
    logic [ROWS_W-1:0]       row_limit;
  } rpd_cmd_t;

  typedef struct packed {
    logic is_sync_first;
    logic is_sync_second;
    logic is_sync_tail;
    logic row_bad;
  } rpd_sts_t;

endpackage

// ===== rtl/rpd_ifs.sv =====
// valid/ready channel interfaces for the byte input and the tagged result
// depends on rpd_pkg
interface rpd_in_if import rpd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface rpd_out_if import rpd_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [PIXEL_W-1:0]   pixel_value;
  logic [ROW_OUT_W-1:0] row_number;
  logic [COL_W-1:0]     column_index;
  logic [FRAME_W-1:0]   frame_id;
  logic                 row_end;

  modport source (output valid, output kind, output pixel_value, output row_number,
                  output column_index, output frame_id, output row_end, input ready);
  modport sink (input valid, input kind, input pixel_value, input row_number,
                input column_index, input frame_id, input row_end, output ready);
endinterface

// ===== rtl/rpd_datapath.sv =====
// deframer datapath: byte select, sync compare, header fields, replay store
// and the result register; depends on rpd_pkg
module rpd_datapath import rpd_pkg::*; (
  input  logic                 clk_i,
  input  logic [BYTE_W-1:0]    in_byte_i,
  input  rpd_cmd_t             cmd_i,
  output rpd_sts_t             sts_o,
  output logic [KIND_W-1:0]    kind_o,
  output logic [PIXEL_W-1:0]   pixel_value_o,
  output logic [ROW_OUT_W-1:0] row_number_o,
  output logic [COL_W-1:0]     column_index_o,
  output logic [FRAME_W-1:0]   frame_id_o,
  output logic                 row_end_o
);

  logic [BYTE_W-1:0]     store_q [REPLAY_DEPTH];
  logic [HELD_ROW_W-1:0] held_row_q;
  logic [FRAME_W-1:0]    held_frame_q;
  logic [BYTE_W-1:0]     low_q;

  logic [KIND_W-1:0]    kind_q;
  logic [PIXEL_W-1:0]   pixel_q;
  logic [ROW_OUT_W-1:0] row_q;
  logic [COL_W-1:0]     col_q;
  logic [FRAME_W-1:0]   frame_q;
  logic                 row_end_q;

  logic [BYTE_W-1:0]     cur_byte;
  logic [HELD_ROW_W-1:0] row_cand;
  logic                  pix_kind;

  assign cur_byte = cmd_i.sel_replay ? store_q[cmd_i.replay_idx] : in_byte_i;
  assign row_cand = {cur_byte, held_row_q[BYTE_W-1:0]};
  assign pix_kind = (cmd_i.out_kind == KIND_PIX_LO) || (cmd_i.out_kind == KIND_PIX_OUT);

  assign sts_o.is_sync_first  = (cur_byte == SYNC_FIRST);
  assign sts_o.is_sync_second = (cur_byte == SYNC_SECOND);
  assign sts_o.is_sync_tail   = (cur_byte == SYNC_TAIL);
  assign sts_o.row_bad        = (row_cand == '0) ||
                                (row_cand > HELD_ROW_W'(cmd_i.row_limit));

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      store_q[cmd_i.store_idx] <= cur_byte;
    end
    if (cmd_i.row_lo_ld) begin
      held_row_q <= HELD_ROW_W'(cur_byte);
    end
    if (cmd_i.row_hi_ld) begin
      held_row_q <= row_cand;
    end
    if (cmd_i.frm_lo_ld) begin
      held_frame_q <= FRAME_W'(cur_byte);
    end
    if (cmd_i.frm_hi_ld) begin
      held_frame_q <= {cur_byte, held_frame_q[BYTE_W-1:0]};
    end
    if (cmd_i.low_ld) begin
      low_q <= cur_byte;
    end
    if (cmd_i.out_ld) begin
      kind_q    <= cmd_i.out_kind;
      row_end_q <= cmd_i.out_row_end;
      pixel_q   <= (cmd_i.out_kind == KIND_PIX_OUT) ? {cur_byte, low_q} : '0;
      row_q     <= pix_kind ? held_row_q[ROW_OUT_W-1:0] : '0;
      col_q     <= pix_kind ? cmd_i.out_col : '0;
      frame_q   <= pix_kind ? held_frame_q : '0;
    end
  end

  assign kind_o         = kind_q;
  assign pixel_value_o  = pixel_q;
  assign row_number_o   = row_q;
  assign column_index_o = col_q;
  assign frame_id_o     = frame_q;
  assign row_end_o      = row_end_q;

endmodule

// ===== rtl/rpd_ctrl.sv =====
// deframer controller: parse phase, sync match, byte and column counters,
// header replay sequencing, config registers and handshakes; depends on rpd_pkg
module rpd_ctrl import rpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rpd_sts_t              sts_i,
  output rpd_cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [1:0]              match_q, match_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic                    replay_q, replay_d;
  logic [REPLAY_IDX_W-1:0] ridx_q, ridx_d;
  logic                    out_valid_q, out_valid_d;
  logic [HDR_LEN_W-1:0]    hdr_len_q;
  logic [PIX_CNT_W-1:0]    row_pix_q;
  logic [ROWS_W-1:0]       frame_rows_q;

  logic [HDR_LEN_W-1:0] eff_hdr;
  logic [PIX_CNT_W-1:0] eff_pix;
  logic [ROWS_W-1:0]    eff_rows;
  logic                 in_fire;
  logic                 step;
  logic                 hdr_end;
  logic                 col_end;
  logic                 expected;
  logic                 reject;
  kind_e                kind;
  logic                 store_we, row_lo_ld, row_hi_ld, frm_lo_ld, frm_hi_ld, low_ld;
  logic                 row_end;

  assign eff_hdr = (hdr_len_q < HDR_LEN_W'(MIN_HEADER_BYTES)) ? HDR_LEN_W'(MIN_HEADER_BYTES) :
                   (hdr_len_q > HDR_LEN_W'(MAX_HEADER_BYTES)) ? HDR_LEN_W'(MAX_HEADER_BYTES) :
                   hdr_len_q;
  assign eff_pix = (row_pix_q == '0) ? PIX_CNT_W'(1) :
                   (row_pix_q > PIX_CNT_W'(MAX_ROW_PIXELS)) ? PIX_CNT_W'(MAX_ROW_PIXELS) :
                   row_pix_q;
  assign eff_rows = (frame_rows_q > ROWS_W'(MAX_FRAME_ROWS)) ? ROWS_W'(MAX_FRAME_ROWS) :
                    frame_rows_q;

  assign in_ready_o = !replay_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign step       = in_fire || replay_q;
  assign hdr_end    = ({1'b0, pos_q} + (POS_W+1)'(1)) >= (POS_W+1)'(eff_hdr);
  assign col_end    = ({1'b0, col_q} + PIX_CNT_W'(1)) >= eff_pix;
  assign expected   = (match_q == 2'd0) ? sts_i.is_sync_first :
                      (match_q == 2'd1) ? sts_i.is_sync_second : sts_i.is_sync_tail;

  always_comb begin
    phase_d   = phase_q;
    match_d   = match_q;
    pos_d     = pos_q;
    col_d     = col_q;
    kind      = KIND_DISCARD;
    reject    = 1'b0;
    store_we  = 1'b0;
    row_lo_ld = 1'b0;
    row_hi_ld = 1'b0;
    frm_lo_ld = 1'b0;
    frm_hi_ld = 1'b0;
    low_ld    = 1'b0;
    row_end   = 1'b0;
    if (step) begin
      case (phase_q)
        PH_HEADER: begin
          store_we  = (pos_q >= POS_W'(REPLAY_FIRST)) &&
                      (pos_q < POS_W'(REPLAY_FIRST + REPLAY_DEPTH));
          row_lo_ld = (pos_q == POS_W'(ROW_OFS));
          row_hi_ld = (pos_q == POS_W'(ROW_OFS + 1));
          if (row_hi_ld && sts_i.row_bad) begin
            reject  = 1'b1;
            kind    = KIND_REJECT;
            phase_d = PH_HUNT;
            match_d = '0;
            pos_d   = '0;
          end else begin
            frm_lo_ld = (pos_q == POS_W'(FRAME_OFS));
            frm_hi_ld = (pos_q == POS_W'(FRAME_OFS + 1));
            kind      = KIND_HELD;
            if (hdr_end) begin
              phase_d = PH_PAYLOAD;
              pos_d   = '0;
              col_d   = '0;
            end else begin
              pos_d = pos_q + POS_W'(1);
            end
          end
        end
        PH_PAYLOAD: begin
          if (!pos_q[0]) begin
            low_ld = 1'b1;
            kind   = KIND_PIX_LO;
            pos_d  = pos_q + POS_W'(1);
          end else begin
            kind = KIND_PIX_OUT;
            if (col_end) begin
              row_end = 1'b1;
              phase_d = PH_HUNT;
              match_d = '0;
              pos_d   = '0;
              col_d   = '0;
            end else begin
              col_d = col_q + COL_W'(1);
              pos_d = pos_q + POS_W'(1);
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (expected) begin
            kind = KIND_HELD;
            if (match_q == 2'd3) begin
              phase_d = PH_HEADER;
              pos_d   = POS_W'(REPLAY_FIRST);
              match_d = '0;
            end else begin
              match_d = match_q + 2'd1;
            end
          end else if (sts_i.is_sync_first) begin
            kind    = KIND_HELD;
            match_d = 2'd1;
          end else begin
            match_d = '0;
          end
        end
      endcase
    end

    replay_d = replay_q;
    ridx_d   = ridx_q;
    if (in_fire && reject) begin
      replay_d = 1'b1;
      ridx_d   = '0;
    end else if (replay_q) begin
      ridx_d = ridx_q + REPLAY_IDX_W'(1);
      if (ridx_q == REPLAY_IDX_W'(REPLAY_DEPTH - 1)) begin
        replay_d = 1'b0;
      end
    end

    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign cmd_o = '{
    sel_replay:  replay_q,
    replay_idx:  ridx_q,
    store_we:    store_we,
    store_idx:   REPLAY_IDX_W'(pos_q - POS_W'(REPLAY_FIRST)),
    row_lo_ld:   row_lo_ld,
    row_hi_ld:   row_hi_ld,
    frm_lo_ld:   frm_lo_ld,
    frm_hi_ld:   frm_hi_ld,
    low_ld:      low_ld,
    out_ld:      in_fire,
    out_kind:    kind,
    out_col:     col_q,
    out_row_end: row_end,
    row_limit:   eff_rows
  };

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      match_q      <= '0;
      pos_q        <= '0;
      col_q        <= '0;
      replay_q     <= 1'b0;
      ridx_q       <= '0;
      out_valid_q  <= 1'b0;
      hdr_len_q    <= HDR_LEN_RESET;
      row_pix_q    <= ROW_PIX_RESET;
      frame_rows_q <= FRAME_ROW_RESET;
    end else begin
      phase_q     <= phase_d;
      match_q     <= match_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      replay_q    <= replay_d;
      ridx_q      <= ridx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HEADER_LENGTH: hdr_len_q    <= cfg_data_i[HDR_LEN_W-1:0];
          CFG_ROW_PIXELS:    row_pix_q    <= cfg_data_i[PIX_CNT_W-1:0];
          CFG_FRAME_ROWS:    frame_rows_q <= cfg_data_i[ROWS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/row_packet_deframer_core.sv =====
// row packet deframer top: one result per accepted byte, registered, the cycle after accept
// throughput one byte per cycle when output is not stalled; a rejected header blocks input
// while the six-entry replay store runs header bytes 4..9 back through the hunter
// async active-low reset clears control state and loads register defaults 12, 640, 512
// depends on rpd_pkg, rpd_ifs, rpd_ctrl, rpd_datapath
module row_packet_deframer_core import rpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rpd_in_if.sink                in_req_i,
  rpd_out_if.source             out_req_o
);

  rpd_cmd_t cmd;
  rpd_sts_t sts;

  rpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_req_i.valid),
    .in_ready_o  (in_req_i.ready),
    .out_valid_o (out_req_o.valid),
    .out_ready_i (out_req_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpd_datapath u_datapath (
    .clk_i          (clk_i),
    .in_byte_i      (in_req_i.stream_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_o         (out_req_o.kind),
    .pixel_value_o  (out_req_o.pixel_value),
    .row_number_o   (out_req_o.row_number),
    .column_index_o (out_req_o.column_index),
    .frame_id_o     (out_req_o.frame_id),
    .row_end_o      (out_req_o.row_end)
  );

  a_replay_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sel_replay |-> !in_req_i.ready)
    else $error("request accepted during header replay");

  a_reject_starts_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req_i.valid && in_req_i.ready && cmd.out_kind == KIND_REJECT)
      |=> (cmd.sel_replay && cmd.replay_idx == '0))
    else $error("rejected header did not start replay");

  a_row_end_on_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_req_o.valid && out_req_o.row_end) |-> out_req_o.kind == KIND_PIX_OUT)
    else $error("row end flagged on a non-pixel result");

  a_store_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store_we |-> cmd.store_idx < REPLAY_IDX_W'(REPLAY_DEPTH))
    else $error("replay store write out of range");

endmodule
